[hw/rtl/sha256_byte_stream_hasher_assert.svh]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher assertion macros
// Concurrent assertion helpers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SBSH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SBSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define SBSH_ASSERT_IMPL(lbl, ante, cons, msg)
`define SBSH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/sbsh_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared types, constants and round functions of the hasher.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [7:0][31:0] t_chain;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned BLK_CNT_W   = 55;

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [2:0] WORD_LAST = 3'd7;

    // Index 0 holds H0.
    localparam t_chain HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef struct packed {
        logic push_byte;
        logic push_word;
        logic push_len;
    } t_buf_ctl;

    typedef struct packed {
        logic start;
        logic init;
    } t_cmp_ctl;

    typedef struct packed {
        logic busy;
        logic run;
    } t_cmp_stat;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word round_const(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        round_const = k;
    endfunction

endpackage

[hw/rtl/sbsh_msgbuf.sv]
// ----------------------------------------------------------------------------
// SHA-256 message buffer and schedule
// 64-byte shift line that collects the block and then runs the message
// schedule in place, one word per round.
// ----------------------------------------------------------------------------
module sbsh_msgbuf (
    input  logic               i_clk,
    input  sbsh_pkg::t_buf_ctl i_ctl,
    input  logic [7:0]         i_data_byte,
    input  logic [63:0]        i_len,
    output sbsh_pkg::t_word    o_w
);

    logic [511:0]    r_blk;
    sbsh_pkg::t_word w0;
    sbsh_pkg::t_word w1;
    sbsh_pkg::t_word w9;
    sbsh_pkg::t_word w14;
    sbsh_pkg::t_word w_next;

    // Word i of the window sits at r_blk[511-32*i -: 32].
    assign w0  = r_blk[511:480];
    assign w1  = r_blk[479:448];
    assign w9  = r_blk[223:192];
    assign w14 = r_blk[63:32];

    assign w_next = sbsh_pkg::small_sigma1(w14) + w9 + sbsh_pkg::small_sigma0(w1) + w0;
    assign o_w    = w0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_word) begin
            r_blk <= {r_blk[479:0], w_next};
        end else if (i_ctl.push_len) begin
            r_blk <= {r_blk[447:0], i_len};
        end else if (i_ctl.push_byte) begin
            r_blk <= {r_blk[503:0], i_data_byte};
        end
    end

endmodule

[hw/rtl/sbsh_compress.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// Chaining words plus one round datapath reused for every round of a block.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_assert.svh"

module sbsh_compress (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbsh_pkg::t_cmp_ctl  i_ctl,
    input  sbsh_pkg::t_word     i_w,
    output sbsh_pkg::t_cmp_stat o_stat,
    output sbsh_pkg::t_chain    o_chain
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_FIN
    } t_state;

    t_state           r_state;
    logic [5:0]       r_rnd;
    sbsh_pkg::t_chain r_chain;
    sbsh_pkg::t_word  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    sbsh_pkg::t_word  t1;
    sbsh_pkg::t_word  t2;
    sbsh_pkg::t_word  ch;
    sbsh_pkg::t_word  maj;

    assign ch  = (r_e & r_f) ^ (~r_e & r_g);
    assign maj = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    assign t1  = r_h + sbsh_pkg::big_sigma1(r_e) + ch + sbsh_pkg::round_const(r_rnd) + i_w;
    assign t2  = sbsh_pkg::big_sigma0(r_a) + maj;

    assign o_stat.busy = (r_state != C_IDLE);
    assign o_stat.run  = (r_state == C_RUN);
    assign o_chain     = r_chain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_rnd   <= '0;
            r_chain <= sbsh_pkg::HASH_INIT;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= C_RUN;
                        r_rnd   <= '0;
                    end else if (i_ctl.init) begin
                        r_chain <= sbsh_pkg::HASH_INIT;
                    end
                end
                C_RUN: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == sbsh_pkg::ROUND_LAST) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    // fold the working words back into the chain
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                    r_chain[5] <= r_chain[5] + r_f;
                    r_chain[6] <= r_chain[6] + r_g;
                    r_chain[7] <= r_chain[7] + r_h;
                    r_state    <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_ctl.start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
            r_f <= r_chain[5];
            r_g <= r_chain[6];
            r_h <= r_chain[7];
        end else if (r_state == C_RUN) begin
            r_h <= r_g;
            r_g <= r_f;
            r_f <= r_e;
            r_e <= r_d + t1;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_a;
            r_a <= t1 + t2;
        end
    end

    `SBSH_ASSERT_IMPL(a_start_idle, i_ctl.start, r_state == C_IDLE, "start while busy")
    `SBSH_ASSERT_IMPL(a_no_init_busy, i_ctl.init, r_state == C_IDLE && !i_ctl.start,
        "chain init during compression")
    `SBSH_ASSERT_NEXT(a_last_round, r_state == C_RUN && r_rnd == sbsh_pkg::ROUND_LAST,
        r_state == C_FIN, "round count overran")
    `SBSH_ASSERT_NEXT(a_fin_once, r_state == C_FIN, r_state == C_IDLE, "fold step repeated")

endmodule

[hw/rtl/sha256_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_msg_byte, i_byte_present, i_end_msg.
// A transaction takes at most one byte; i_end_msg closes the message.
// Output channel: o_valid / i_stall with o_digest_word, o_word_index and
// o_last_word, eight transactions per message, word 0 first.
// A plain byte does not stall the input. The byte that fills a block stalls
// the input while the block is compressed: a start step, the rounds, a fold
// step and a step to resume. All of it is set by the single round unit.
// After end of message the pad bytes go in one per cycle, save while an extra
// block is compressed (56 - fill, or 64 - fill + 56 with an extra block); the
// length word then closes the last block, which is compressed, and the first
// digest word is valid once S_WAIT has passed to S_DONE and the digest is loaded.
// The digest is copied to an output register and the hasher starts the next
// message at once; a stalled receiver holds the next message in S_DONE.
// Reset loads the initial hash values and clears the byte and block counts;
// the block buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_msg,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_ZERO,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                            r_state, n_state;
    t_state                            r_after, n_after;
    logic [5:0]                        r_fill, n_fill;
    logic [5:0]                        r_lenfill, n_lenfill;
    logic [sbsh_pkg::BLK_CNT_W-1:0]    r_blocks, n_blocks;
    logic                              r_out_valid;
    logic [2:0]                        r_oidx;
    sbsh_pkg::t_chain                  r_dig;

    sbsh_pkg::t_buf_ctl  buf_ctl;
    sbsh_pkg::t_cmp_ctl  cmp_ctl;
    sbsh_pkg::t_cmp_stat cmp_stat;
    sbsh_pkg::t_chain    chain;
    sbsh_pkg::t_word     w_cur;
    logic [7:0]          buf_byte;
    logic [63:0]         buf_len;
    logic                in_acc;
    logic                out_acc;
    logic                load_dig;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign buf_len = {r_blocks, r_lenfill, 3'b000};

    sbsh_msgbuf u_msgbuf (
        .i_clk       (i_clk),
        .i_ctl       (buf_ctl),
        .i_data_byte (buf_byte),
        .i_len       (buf_len),
        .o_w         (w_cur)
    );

    sbsh_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cmp_ctl),
        .i_w     (w_cur),
        .o_stat  (cmp_stat),
        .o_chain (chain)
    );

    always_comb begin
        n_state           = r_state;
        n_after           = r_after;
        n_fill            = r_fill;
        n_lenfill         = r_lenfill;
        n_blocks          = r_blocks;
        buf_ctl.push_byte = 1'b0;
        buf_ctl.push_word = cmp_stat.run;
        buf_ctl.push_len  = 1'b0;
        buf_byte          = i_msg_byte;
        cmp_ctl.start     = 1'b0;
        cmp_ctl.init      = 1'b0;
        load_dig          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present) begin
                        buf_ctl.push_byte = 1'b1;
                        if (r_fill == sbsh_pkg::FILL_LAST) begin
                            cmp_ctl.start = 1'b1;
                            n_blocks      = r_blocks + 1'b1;
                            n_fill        = '0;
                            n_state       = S_WAIT;
                            n_after       = i_end_msg ? S_PAD80 : S_IDLE;
                        end else begin
                            n_fill = r_fill + 6'd1;
                            if (i_end_msg) begin
                                n_state = S_PAD80;
                            end
                        end
                    end else if (i_end_msg) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                buf_ctl.push_byte = 1'b1;
                buf_byte          = sbsh_pkg::PAD_BYTE;
                n_lenfill         = r_fill;
                n_fill            = r_fill + 6'd1;
                if (r_fill == sbsh_pkg::FILL_LAST) begin
                    // pad byte closes the block: extra block follows
                    cmp_ctl.start = 1'b1;
                    n_state       = S_WAIT;
                    n_after       = S_ZERO;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (r_fill == sbsh_pkg::LEN_POS) begin
                    buf_ctl.push_len = 1'b1;
                    cmp_ctl.start    = 1'b1;
                    n_fill           = '0;
                    n_state          = S_WAIT;
                    n_after          = S_DONE;
                end else begin
                    buf_ctl.push_byte = 1'b1;
                    buf_byte          = sbsh_pkg::ZERO_BYTE;
                    n_fill            = r_fill + 6'd1;
                    if (r_fill == sbsh_pkg::FILL_LAST) begin
                        cmp_ctl.start = 1'b1;
                        n_state       = S_WAIT;
                        n_after       = S_ZERO;
                    end
                end
            end
            S_WAIT: begin
                if (!cmp_stat.busy) begin
                    n_state = r_after;
                end
            end
            S_DONE: begin
                // hold until the previous digest has drained
                if (!r_out_valid) begin
                    load_dig     = 1'b1;
                    cmp_ctl.init = 1'b1;
                    n_blocks     = '0;
                    n_fill       = '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_fill      <= '0;
            r_lenfill   <= '0;
            r_blocks    <= '0;
            r_out_valid <= 1'b0;
            r_oidx      <= '0;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_fill    <= n_fill;
            r_lenfill <= n_lenfill;
            r_blocks  <= n_blocks;
            // Digest shift line: word 0 sits at the bottom.
            if (load_dig) begin
                r_out_valid <= 1'b1;
                r_oidx      <= '0;
                r_dig       <= chain;
            end else if (out_acc) begin
                r_oidx <= r_oidx + 3'd1;
                r_dig  <= {32'h0, r_dig[7:1]};
                if (r_oidx == sbsh_pkg::WORD_LAST) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_digest_word = r_dig[0];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == sbsh_pkg::WORD_LAST);

    `SBSH_ASSERT_NEXT(a_last_drains, out_acc && r_oidx == sbsh_pkg::WORD_LAST, !o_valid,
        "digest kept after last word")
    `SBSH_ASSERT_NEXT(a_digest_load, r_state == S_DONE && !r_out_valid,
        o_valid && o_word_index == 3'd0 && r_state == S_IDLE, "digest not loaded")
    `SBSH_ASSERT_NEXT(a_block_full, in_acc && i_byte_present && r_fill == sbsh_pkg::FILL_LAST,
        r_state == S_WAIT && r_fill == 6'd0, "full block not compressed")
    `SBSH_ASSERT_IMPL(a_push_excl, buf_ctl.push_word, !buf_ctl.push_byte && !buf_ctl.push_len,
        "buffer written during compression")

endmodule
